>>> hw/rtl/fr_pkg.sv
// Shared types and constants for the flooding router.
package fr_pkg;

	localparam int HOP_W      = 4;
	localparam int LINK_W     = 5;
	localparam int ADDR_W     = 8;
	localparam int SEQ_W      = 8;
	localparam int MASK_W     = 32;
	localparam int MAX_HOPS   = 4;
	localparam int ADDR_SPAN  = 256;

	localparam logic [0:0] REG_NODE_ADDR  = 1'b0;
	localparam logic [0:0] REG_LINK_COUNT = 1'b1;

	typedef enum logic {
		FUNC_APP  = 1'b0,
		FUNC_LINK = 1'b1
	} func_t;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_ACK  = 1'b1
	} kind_t;

	typedef struct packed {
		func_t              func;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dest;
		kind_t              kind;
		logic [SEQ_W-1:0]   seq;
		logic [HOP_W-1:0]   hops;
		logic [LINK_W-1:0]  link;
	} item_t;

	typedef struct packed {
		logic [MASK_W-1:0]  link_mask;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dest;
		kind_t              kind;
		logic [SEQ_W-1:0]   seq;
		logic [HOP_W-1:0]   hops;
		logic               deliver;
		logic               app_enable;
		logic               app_disable;
	} res_t;

	// One table row per address: the three per-address counters side by side.
	typedef struct packed {
		logic [SEQ_W-1:0] ack;
		logic [SEQ_W-1:0] data;
		logic [SEQ_W-1:0] send;
	} seq_row_t;

	typedef struct packed {
		logic     en;
		seq_row_t row;
	} wb_t;

endpackage

>>> hw/rtl/fr_seq_table.sv
// Per-address sequence table: row memory, row valid flags and write forwarding.
module fr_seq_table
	import fr_pkg::*;
#(
	parameter int DEPTH = 256,
	localparam int SLOT_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_slot,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_slot,
	input  seq_row_t          wr_row,
	output seq_row_t          rd_row
);

	seq_row_t          mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	seq_row_t          mem_rd_s1;
	seq_row_t          byp_row_s1;
	logic              vld_s1;
	logic              hit_s1;
	logic              hit;

	assign hit = wr_en && (wr_slot == rd_slot);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= wr_row;
		end
		if (rd_en) begin
			mem_rd_s1  <= mem[rd_slot];
			byp_row_s1 <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_slot] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_slot];
				hit_s1 <= hit;
			end
		end
	end

	// a row never written reads as zero; a row being written as it is read takes the new value
	assign rd_row = hit_s1 ? byp_row_s1 : (vld_s1 ? mem_rd_s1 : seq_row_t'('0));

`ifndef NO_ASSERTIONS
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && hit |=> rd_row == $past(wr_row))
		else $error("read of a row under write did not return the written value");
`endif

endmodule

>>> hw/rtl/fr_decide.sv
// Routing decision for one request: flood, ack, deliver, forward or drop.
module fr_decide
	import fr_pkg::*;
(
	input  item_t             item,
	input  seq_row_t          row,
	input  logic [ADDR_W-1:0] node_addr,
	input  logic [LINK_W-1:0] link_cnt,
	output res_t              res,
	output wb_t               wb
);

	logic [MASK_W-1:0] link_set;
	logic [MASK_W-1:0] arrival;
	logic [MASK_W-1:0] mask;
	logic [HOP_W:0]    raised;

	always_comb begin
		for (int k = 0; k < MASK_W; k++) begin
			link_set[k] = (k != 0) && (k <= int'(link_cnt));
		end
	end

	assign arrival = MASK_W'(1) << item.link;
	assign raised  = {1'b0, item.hops} + (HOP_W+1)'(1);

	always_comb begin
		res    = '0;
		wb.en  = 1'b0;
		wb.row = row;
		mask   = '0;
		if (item.func == FUNC_APP) begin
			res.link_mask   = link_set;
			res.src         = node_addr;
			res.dest        = item.dest;
			res.kind        = KIND_DATA;
			res.seq         = row.send;
			res.app_disable = 1'b1;
			wb.en           = 1'b1;
			wb.row.send     = row.send + SEQ_W'(1);
		end else if (item.dest == node_addr) begin
			if (item.kind == KIND_DATA) begin
				if (item.seq == row.data) begin
					wb.en       = 1'b1;
					wb.row.data = row.data + SEQ_W'(1);
					res.deliver = 1'b1;
					// ack goes back on the arrival link only, if that link exists
					mask          = arrival & link_set;
					res.link_mask = mask;
					if (mask != '0) begin
						res.src  = node_addr;
						res.dest = item.src;
						res.kind = KIND_ACK;
						res.seq  = item.seq;
					end
				end
			end else if (item.seq == row.ack) begin
				wb.en          = 1'b1;
				wb.row.ack     = row.ack + SEQ_W'(1);
				res.app_enable = 1'b1;
			end
		end else if (raised < (HOP_W+1)'(MAX_HOPS)) begin
			mask          = link_set & ~arrival;
			res.link_mask = mask;
			if (mask != '0) begin
				res.src  = item.src;
				res.dest = item.dest;
				res.kind = item.kind;
				res.seq  = item.seq;
				res.hops = raised[HOP_W-1:0];
			end
		end
	end

endmodule

>>> hw/rtl/flood_router_with_seq_ack_top.sv
// Flooding router top level: request stage, table, decision and result register.
// Pipeline: a request is held in the request stage, where it is decided, and its result in the
// result register, which drives m_tvalid; a low m_tready with a result waiting stalls both.
// Throughput: one request per cycle while not stalled; the table read-modify-write spans the
// request stage and a write-to-read forward serves back-to-back requests to the same address.
// Reset: arst_n clears pipeline valids, the table row flags (rows then read as zero) and
// sets node_address to 0 and link_count to 1; the table needs no clearing pass.
module flood_router_with_seq_ack_top
	import fr_pkg::*;
#(
	parameter int NODE_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// src[7:0], dest[15:8], seq_number[23:16], hop_count[27:24], arrived_link[32:28]
	input  logic [39:0] s_tdata,
	// func[0], kind[1]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// link_mask[31:0], out_src[39:32], out_dest[47:40], out_seq[55:48], out_hops[59:56],
	// deliver[60], app_enable[61], app_disable[62]
	output logic [63:0] m_tdata,
	// out_kind[0]
	output logic [0:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SLOT_W = $clog2(NODE_COUNT);

	logic [ADDR_W-1:0] node_addr_q;
	logic [LINK_W-1:0] link_cnt_q;
	logic              cfg_wr;

	item_t             in_item;
	logic              accept;
	logic              adv_s1;
	logic [SLOT_W-1:0] slot_lut [ADDR_SPAN];
	logic [SLOT_W-1:0] rd_slot;

	item_t             item_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              valid_s1;
	seq_row_t          row;
	res_t              res;
	wb_t               wb;

	res_t              res_s2;
	logic              valid_s2;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_LINK_COUNT) ? {{(32-LINK_W){1'b0}}, link_cnt_q}
	                                             : {{(32-ADDR_W){1'b0}}, node_addr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_addr_q <= '0;
			link_cnt_q  <= LINK_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_NODE_ADDR:  node_addr_q <= pwdata[ADDR_W-1:0];
				REG_LINK_COUNT: link_cnt_q  <= pwdata[LINK_W-1:0];
				default: ;
			endcase
		end
	end

	// table slot of every address, worked out at elaboration
	for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_slot
		assign slot_lut[g] = SLOT_W'(g % NODE_COUNT);
	end

	assign in_item.func = func_t'(s_tuser[0]);
	assign in_item.kind = kind_t'(s_tuser[1]);
	assign in_item.src  = s_tdata[7:0];
	assign in_item.dest = s_tdata[15:8];
	assign in_item.seq  = s_tdata[23:16];
	assign in_item.hops = s_tdata[27:24];
	assign in_item.link = s_tdata[32:28];

	assign rd_slot = (in_item.func == FUNC_APP) ? slot_lut[in_item.dest] : slot_lut[in_item.src];

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
			slot_s1 <= rd_slot;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	fr_seq_table #(
		.DEPTH (NODE_COUNT)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_slot (rd_slot),
		.wr_en   (adv_s1 && wb.en),
		.wr_slot (slot_s1),
		.wr_row  (wb.row),
		.rd_row  (row)
	);

	fr_decide u_decide (
		.item      (item_s1),
		.row       (row),
		.node_addr (node_addr_q),
		.link_cnt  (link_cnt_q),
		.res       (res),
		.wb        (wb)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {1'b0, res_s2.app_disable, res_s2.app_enable, res_s2.deliver,
	                   res_s2.hops, res_s2.seq, res_s2.dest, res_s2.src, res_s2.link_mask};

`ifndef NO_ASSERTIONS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1) && $stable(slot_s1))
		else $error("stalled request stage lost or changed its request");

	// a new message keeps its header even when there are no links to send it on
	a_empty_header: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_s2.link_mask == '0) && !res_s2.app_disable |->
			res_s2.src == '0 && res_s2.dest == '0 && res_s2.seq == '0 &&
			res_s2.hops == '0 && res_s2.kind == KIND_DATA)
		else $error("header fields set on a result that sends nothing");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones({res_s2.deliver, res_s2.app_enable, res_s2.app_disable}) <= 1)
		else $error("more than one application flag on one result");
`endif

endmodule
